// ----- rtl/phlt_pkg.sv -----
package phlt_pkg;

    localparam logic [1:0] ST_FREE   = 2'd0;
    localparam logic [1:0] ST_ACTIVE = 2'd1;
    localparam logic [1:0] ST_LOST   = 2'd2;

    localparam logic [1:0] EV_RECONNECTED = 2'd0;
    localparam logic [1:0] EV_LOST        = 2'd1;
    localparam logic [1:0] EV_FULL        = 2'd2;

    localparam logic       ACT_HEARTBEAT = 1'b0;
    localparam logic       ACT_TICK      = 1'b1;

    localparam logic [7:0] AGE_MAX       = 8'd255;
    localparam logic [7:0] TIMEOUT_RESET = 8'd3;
    localparam int         MAX_EVENTS    = 16;
    localparam int         NEV_W         = $clog2(MAX_EVENTS + 1);

    typedef struct packed {
        logic        action;
        logic [31:0] peer_addr;
        logic [15:0] peer_port;
    } t_in;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [31:0] event_addr;
        logic [15:0] event_port;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] addr;
        logic [15:0] port;
        logic [7:0]  age;
    } t_slot;

endpackage

// ----- rtl/peer_heartbeat_liveness_table.sv -----
// operation: an item is taken in the idle state, then a scan state passes every slot
//   through the ring head and a flush state sends out the held last event, marked last
// a new item is taken only once the last one is done; a heartbeat from a new peer
//   needs a second ring rotation to write the slot; output stalls hold the ring rotation
// reset: synchronous, all slots free at age zero, timeout 3, no beat pending
module peer_heartbeat_liveness_table #(
    parameter int PEERS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  phlt_pkg::t_in  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output phlt_pkg::t_out o_out_data,
    input  logic           i_out_stall,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [7:0]     i_cfg_data
);
    import phlt_pkg::*;

    logic [7:0] r_timeout;
    t_slot      w_slot [PEERS];
    t_slot      w_head_new;
    logic       w_shift;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout <= i_cfg_data;
        end
    end

    // ring of slots: cell 0 is the head, its updated record re-enters at the tail
    for (genvar g = 0; g < PEERS; g++) begin : g_cell
        if (g == PEERS - 1) begin : g_tail
            phlt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_slot  (w_head_new),
                .o_slot  (w_slot[g])
            );
        end else begin : g_mid
            phlt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_slot  (w_slot[g+1]),
                .o_slot  (w_slot[g])
            );
        end
    end

    phlt_ctrl #(
        .PEERS (PEERS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_timeout   (r_timeout),
        .i_head_slot (w_slot[0]),
        .o_head_slot (w_head_new),
        .o_shift     (w_shift)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken but block did not go busy");

    a_res_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.event_res == EV_RECONNECTED ||
                         o_out_data.event_res == EV_LOST ||
                         o_out_data.event_res == EV_FULL))
        else $error("event code out of range");

    a_single_hb_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.event_res == EV_RECONNECTED ||
                         o_out_data.event_res == EV_FULL)) |-> o_out_data.last)
        else $error("heartbeat event not marked last");

    a_no_shift_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift |-> o_in_stall)
        else $error("ring rotated while idle");

endmodule

// ----- rtl/phlt_cell.sv -----
module phlt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  phlt_pkg::t_slot i_slot,
    output phlt_pkg::t_slot o_slot
);
    import phlt_pkg::*;

    logic [1:0]  r_status;
    logic [7:0]  r_age;
    logic [31:0] r_addr;
    logic [15:0] r_port;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= ST_FREE;
            r_age    <= '0;
        end else if (i_shift) begin
            r_status <= i_slot.status;
            r_age    <= i_slot.age;
        end
    end

    // peer key is only read once the slot has been taken
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_addr <= i_slot.addr;
            r_port <= i_slot.port;
        end
    end

    assign o_slot = '{status: r_status, addr: r_addr, port: r_port, age: r_age};

endmodule

// ----- rtl/phlt_ctrl.sv -----
module phlt_ctrl #(
    parameter int PEERS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  phlt_pkg::t_in   i_in_data,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output phlt_pkg::t_out  o_out_data,
    input  logic            i_out_stall,
    input  logic [7:0]      i_timeout,
    input  phlt_pkg::t_slot i_head_slot,
    output phlt_pkg::t_slot o_head_slot,
    output logic            o_shift
);
    import phlt_pkg::*;

    localparam int CW = $clog2(PEERS + 1);
    localparam logic [CW-1:0] LAST_SLOT = CW'(PEERS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_ALLOC = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]       r_state,    n_state;
    logic [CW-1:0]    r_cnt,      n_cnt;
    t_in              r_item,     n_item;
    logic             r_done,     n_done;
    logic             r_free_v,   n_free_v;
    logic [CW-1:0]    r_free_idx, n_free_idx;
    logic             r_lost_v,   n_lost_v;
    logic [CW-1:0]    r_lost_idx, n_lost_idx;
    logic [NEV_W-1:0] r_nev,      n_nev;
    logic             r_held_v,   n_held_v;
    t_out             r_held,     n_held;
    logic             r_out_v,    n_out_v;
    t_out             r_out,      n_out;

    logic    out_free;
    logic    last_slot;
    logic    ev;
    t_out    ev_beat;
    t_slot   slot_new;
    logic    s_done, s_free_v, s_lost_v;
    logic [CW-1:0] s_free_idx, s_lost_idx;
    logic [7:0]    age_inc;
    logic    key_hit;
    logic [CW-1:0] tgt;

    always_comb begin
        out_free   = !r_out_v || !i_out_stall;
        last_slot  = (r_cnt == LAST_SLOT);
        age_inc    = (i_head_slot.age < AGE_MAX) ? i_head_slot.age + 8'd1 : i_head_slot.age;
        key_hit    = (i_head_slot.addr == r_item.peer_addr) &&
                     (i_head_slot.port == r_item.peer_port);
        tgt        = r_free_v ? r_free_idx : r_lost_idx;

        // what the head slot becomes in a scan step
        slot_new   = i_head_slot;
        ev         = 1'b0;
        ev_beat    = '{event_res: EV_LOST, event_addr: i_head_slot.addr,
                       event_port: i_head_slot.port, last: 1'b0};
        s_done     = r_done;
        s_free_v   = r_free_v;
        s_free_idx = r_free_idx;
        s_lost_v   = r_lost_v;
        s_lost_idx = r_lost_idx;

        if (r_item.action == ACT_TICK) begin
            if (i_head_slot.status == ST_ACTIVE) begin
                slot_new.age = age_inc;
                if (age_inc >= i_timeout && r_nev < NEV_W'(MAX_EVENTS)) begin
                    slot_new.status = ST_LOST;
                    ev = 1'b1;
                end
            end
        end else if (!r_done) begin
            if (i_head_slot.status == ST_FREE) begin
                if (!r_free_v) begin
                    s_free_v   = 1'b1;
                    s_free_idx = r_cnt;
                end
            end else if (key_hit) begin
                s_done       = 1'b1;
                slot_new.age = '0;
                if (i_head_slot.status == ST_LOST) begin
                    slot_new.status = ST_ACTIVE;
                    ev = 1'b1;
                    ev_beat = '{event_res: EV_RECONNECTED, event_addr: r_item.peer_addr,
                                event_port: r_item.peer_port, last: 1'b0};
                end
            end else if (i_head_slot.status == ST_LOST && !r_lost_v) begin
                s_lost_v   = 1'b1;
                s_lost_idx = r_cnt;
            end
            // no match, no free and no lost slot anywhere: table full
            if (last_slot && !s_done && !s_free_v && !s_lost_v) begin
                ev = 1'b1;
                ev_beat = '{event_res: EV_FULL, event_addr: r_item.peer_addr,
                            event_port: r_item.peer_port, last: 1'b0};
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_item     = r_item;
        n_done     = r_done;
        n_free_v   = r_free_v;
        n_free_idx = r_free_idx;
        n_lost_v   = r_lost_v;
        n_lost_idx = r_lost_idx;
        n_nev      = r_nev;
        n_held_v   = r_held_v;
        n_held     = r_held;
        n_out_v    = r_out_v;
        n_out      = r_out;
        o_shift    = 1'b0;
        o_head_slot = i_head_slot;

        if (r_out_v && !i_out_stall) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item   = i_in_data;
                    n_cnt    = '0;
                    n_done   = 1'b0;
                    n_free_v = 1'b0;
                    n_lost_v = 1'b0;
                    n_nev    = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                // hold the ring when a new beat has nowhere to go
                if (!(ev && r_held_v && !out_free)) begin
                    o_shift     = 1'b1;
                    o_head_slot = slot_new;
                    n_done      = s_done;
                    n_free_v    = s_free_v;
                    n_free_idx  = s_free_idx;
                    n_lost_v    = s_lost_v;
                    n_lost_idx  = s_lost_idx;
                    n_cnt       = r_cnt + CW'(1);
                    if (ev) begin
                        if (r_held_v) begin
                            n_out   = r_held;
                            n_out_v = 1'b1;
                        end
                        n_held   = ev_beat;
                        n_held_v = 1'b1;
                        n_nev    = r_nev + NEV_W'(1);
                    end
                    if (last_slot) begin
                        n_cnt = '0;
                        if (r_item.action == ACT_HEARTBEAT && !s_done &&
                            (s_free_v || s_lost_v)) begin
                            n_state = S_ALLOC;
                        end else begin
                            n_state = S_FLUSH;
                        end
                    end
                end
            end
            S_ALLOC: begin
                o_shift = 1'b1;
                if (r_cnt == tgt) begin
                    o_head_slot = '{status: ST_ACTIVE, addr: r_item.peer_addr,
                                    port: r_item.peer_port, age: 8'd0};
                end
                n_cnt = r_cnt + CW'(1);
                if (last_slot) begin
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (!r_held_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out      = r_held;
                    n_out.last = 1'b1;
                    n_out_v    = 1'b1;
                    n_held_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_held_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_held_v <= n_held_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_item     <= n_item;
        r_done     <= n_done;
        r_free_v   <= n_free_v;
        r_free_idx <= n_free_idx;
        r_lost_v   <= n_lost_v;
        r_lost_idx <= n_lost_idx;
        r_nev      <= n_nev;
        r_held     <= n_held;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule
